### rtl/pfr_pkg.sv
// Package for the process FIFO with removal: opcodes, status codes and the
// per-cycle control word that the top level broadcasts to the cell row.
// No dependencies.
package pfr_pkg;

   localparam int OPCODE_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_POP     = 2'd1,
      OP_REMOVE  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Broadcast control for every cell in one cycle.
   typedef struct packed {
      logic enq;        // append at the first free cell
      logic shift_all;  // pop: every cell takes its neighbor's entry
      logic remove;     // remove: cells at and after the first match shift
   } cell_ctrl_type;

endpackage

### rtl/pfr_req_if.sv
// Request channel of the process FIFO: valid/ready handshake with opcode and
// identifier. Depends on pfr_pkg.
interface pfr_req_if
   import pfr_pkg::*;
#(
   parameter int ID_BITS = 8
);
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [ID_BITS-1:0]     process_id;

   modport source (output valid, output opcode, output process_id, input ready);
   modport sink   (input valid, input opcode, input process_id, output ready);
endinterface

### rtl/pfr_rsp_if.sv
// Response channel of the process FIFO: valid/ready handshake with status,
// popped identifier and occupancy. Depends on pfr_pkg.
interface pfr_rsp_if
   import pfr_pkg::*;
#(
   parameter int ID_BITS = 8
);
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [ID_BITS-1:0]     popped_id;
   logic [OCC_BITS-1:0]    occupancy;

   modport source (output valid, output status, output popped_id, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input popped_id, input occupancy,
                   output ready);
endinterface

### rtl/pfr_cell.sv
// One storage cell of the compacting queue: holds an identifier and an
// occupied flag and takes its right neighbor's contents when shifting.
// Depends on pfr_pkg.
module pfr_cell
   import pfr_pkg::*;
#(
   parameter int ID_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [ID_BITS-1:0] id,
   input  logic               prev_occ,
   input  logic               kill_in,
   input  logic               next_occ,
   input  logic [ID_BITS-1:0] next_data,
   output logic               occ,
   output logic [ID_BITS-1:0] data,
   output logic               kill_out
);

   logic               occ_ff, occ_in;
   logic [ID_BITS-1:0] data_ff, data_in;
   logic               shift;

   // A match in this cell or any cell nearer the head makes this cell shift.
   assign kill_out = kill_in | (occ_ff & (data_ff == id));
   assign shift    = ctrl.shift_all | (ctrl.remove & kill_out);

   always_comb begin
      priority if (shift) begin
         occ_in  = next_occ;
         data_in = next_data;
      end else if (ctrl.enq && !occ_ff && prev_occ) begin
         occ_in  = 1'b1;
         data_in = id;
      end else begin
         occ_in  = occ_ff;
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign occ  = occ_ff;
   assign data = data_ff;

endmodule

### rtl/pfr_chain.sv
// Row of queue cells, head in cell 0. Links occupancy, data and the
// first-match chain between neighbors. Depends on pfr_pkg and pfr_cell.
module pfr_chain
   import pfr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [ID_BITS-1:0] id,
   output logic [ID_BITS-1:0] head_id,
   output logic               found
);

   logic               occ  [QUEUE_DEPTH];
   logic [ID_BITS-1:0] data [QUEUE_DEPTH];
   logic               kill [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic               prev_occ, kill_in, next_occ;
      logic [ID_BITS-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_occ = 1'b1;
         assign kill_in  = 1'b0;
      end else begin : g_body
         assign prev_occ = occ[i-1];
         assign kill_in  = kill[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_occ  = 1'b0;
         assign next_data = '0;
      end else begin : g_inner
         assign next_occ  = occ[i+1];
         assign next_data = data[i+1];
      end

      pfr_cell #(.ID_BITS(ID_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .id        (id),
         .prev_occ  (prev_occ),
         .kill_in   (kill_in),
         .next_occ  (next_occ),
         .next_data (next_data),
         .occ       (occ[i]),
         .data      (data[i]),
         .kill_out  (kill[i])
      );
   end

   assign head_id = data[0];
   assign found   = kill[QUEUE_DEPTH-1];

endmodule

### rtl/process_fifo_with_removal.sv
// Process FIFO with removal: a compacting queue of process identifiers.
// The response word is registered and is valid in the cycle after the request word is accepted.
// Throughput: one request word per cycle, since every cell compares and shifts in the
// same cycle; a response word that is not taken holds off the request side.
// Reset clears the occupied flags, the entry count and the response valid flag;
// cell contents are left as they are and there is no clearing pass.
module process_fifo_with_removal
   import pfr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input logic    clock,
   input logic    reset,
   pfr_req_if.sink   req_chan,
   pfr_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Entry count, kept beside the cells so that full and empty are cheap.
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Response register parts the two sides of the block.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]  rsp_popped_ff, rsp_popped_in;
   logic [OCC_BITS-1:0] rsp_occ_ff, rsp_occ_in;

   logic                accept;
   logic                full, empty;
   logic                found;
   logic [ID_BITS-1:0]  head_id;
   cell_ctrl_type       ctrl;
   logic [CNT_BITS+OCC_BITS-1:0] occ_wide;

   // A new request word is taken whenever the response register is free or
   // is being drained in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   pfr_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .id      (req_chan.process_id),
      .head_id (head_id),
      .found   (found)
   );

   // Decode the operation, drive the cell row and form the response. An
   // unused opcode leaves the queue alone and reports ok.
   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_popped_in = '0;
      unique case (req_chan.opcode)
         OP_ENQUEUE: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctrl.enq = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               ctrl.shift_all = accept;
               rsp_popped_in  = head_id;
               count_in       = count_ff - 1'b1;
            end
         end
         OP_REMOVE: begin
            // The cells shift only where the match chain fired, so the
            // remove strobe can go out unconditionally.
            ctrl.remove = accept;
            if (found) begin
               count_in = count_ff - 1'b1;
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   // Occupancy reports the count after the operation, cut to the field width.
   assign occ_wide   = (CNT_BITS + OCC_BITS)'(count_in);
   assign rsp_occ_in = occ_wide[OCC_BITS-1:0];

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.popped_id = rsp_popped_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

   // The count never runs past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   // The count only moves together with a response load, so a pending
   // response always reports the current count.
   a_occ_tracks_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_occ_ff == OCC_BITS'(count_ff))
      else $error("pending occupancy disagrees with entry count");

   // An accepted request word always yields a response word next cycle.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // A pop on an empty queue reports empty and returns zero.
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.opcode == OP_POP && empty)
      |=> (rsp_status_ff == ST_EMPTY && rsp_popped_ff == '0))
      else $error("pop on empty queue misreported");

endmodule
